FILE: hw/rtl/irpsg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// irpsg_pkg
// Shared types and constants of the IR pulse sequence generator.
// ============================================================================
package irpsg_pkg;

    localparam int DUR_W     = 16;
    localparam int WORD_W    = 32;
    localparam int COUNT_W   = 6;
    localparam int CFG_IDX_W = 3;
    localparam int MAX_BITS_DEFAULT = 30;

    localparam logic [DUR_W-1:0] HDR_HIGH_RESET  = 16'd2220;
    localparam logic [DUR_W-1:0] HDR_LOW_RESET   = 16'd720;
    localparam logic [DUR_W-1:0] DELAY_RESET     = 16'd750;
    localparam logic [DUR_W-1:0] ZERO_BIT_RESET  = 16'd720;
    localparam logic [DUR_W-1:0] ONE_BIT_RESET   = 16'd1450;
    localparam logic             DELAY_MODE_RESET = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_HDR_HIGH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HDR_LOW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_BIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_BIT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_MODE = 3'd5;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HDR_HIGH,
        PH_HDR_LOW,
        PH_DELAY0,
        PH_BIT,
        PH_GAP,
        PH_REJECT
    } phase_t;

    typedef enum logic [2:0] {
        SEL_NONE,
        SEL_HDR_HIGH,
        SEL_HDR_LOW,
        SEL_DELAY,
        SEL_BIT
    } dur_sel_t;

    typedef struct packed {
        logic     load;
        logic     emit;
        dur_sel_t sel;
        logic     last;
        logic     rejected;
        logic     advance;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic hdr_high_nz;
        logic hdr_low_nz;
        logic delay_mode;
        logic bad_cmd;
        logic final_bit;
    } dp_status_t;

endpackage
`default_nettype wire

FILE: hw/rtl/irpsg_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// irpsg_ctrl
// Sequencer state machine: steps through header, delay and bit phases, or a reject phase for a bad command.
// ============================================================================
module irpsg_ctrl (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    s_valid,
    output logic                   s_ready,
    input  wire irpsg_pkg::dp_status_t status,
    output irpsg_pkg::dp_cmd_t     cmd
);

    irpsg_pkg::phase_t phase_reg;
    irpsg_pkg::phase_t phase_next;
    logic              accept;
    irpsg_pkg::phase_t after_hdr_low;

    assign s_ready = (phase_reg == irpsg_pkg::PH_IDLE);
    assign accept  = s_valid && s_ready;
    assign after_hdr_low = status.delay_mode ? irpsg_pkg::PH_DELAY0 : irpsg_pkg::PH_BIT;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= irpsg_pkg::PH_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            irpsg_pkg::PH_IDLE: begin
                if (accept) begin
                    if (status.bad_cmd) begin
                        phase_next = irpsg_pkg::PH_REJECT;
                    end else if (status.hdr_high_nz) begin
                        phase_next = irpsg_pkg::PH_HDR_HIGH;
                    end else if (status.hdr_low_nz) begin
                        phase_next = irpsg_pkg::PH_HDR_LOW;
                    end else begin
                        phase_next = after_hdr_low;
                    end
                end
            end
            irpsg_pkg::PH_HDR_HIGH: begin
                if (status.out_free) begin
                    phase_next = status.hdr_low_nz ? irpsg_pkg::PH_HDR_LOW : after_hdr_low;
                end
            end
            irpsg_pkg::PH_HDR_LOW: begin
                if (status.out_free) begin
                    phase_next = after_hdr_low;
                end
            end
            irpsg_pkg::PH_DELAY0: begin
                if (status.out_free) begin
                    phase_next = irpsg_pkg::PH_BIT;
                end
            end
            irpsg_pkg::PH_BIT: begin
                if (status.out_free) begin
                    phase_next = irpsg_pkg::PH_GAP;
                end
            end
            irpsg_pkg::PH_GAP: begin
                if (status.out_free) begin
                    phase_next = status.final_bit ? irpsg_pkg::PH_IDLE : irpsg_pkg::PH_BIT;
                end
            end
            irpsg_pkg::PH_REJECT: begin
                if (status.out_free) begin
                    phase_next = irpsg_pkg::PH_IDLE;
                end
            end
            default: begin
                phase_next = irpsg_pkg::PH_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.sel      = irpsg_pkg::SEL_NONE;
        cmd.load     = accept && !status.bad_cmd;
        case (phase_reg)
            irpsg_pkg::PH_HDR_HIGH: begin
                cmd.emit = status.out_free;
                cmd.sel  = irpsg_pkg::SEL_HDR_HIGH;
            end
            irpsg_pkg::PH_HDR_LOW: begin
                cmd.emit = status.out_free;
                cmd.sel  = irpsg_pkg::SEL_HDR_LOW;
            end
            irpsg_pkg::PH_DELAY0: begin
                cmd.emit = status.out_free;
                cmd.sel  = irpsg_pkg::SEL_DELAY;
            end
            irpsg_pkg::PH_BIT: begin
                cmd.emit = status.out_free;
                cmd.sel  = irpsg_pkg::SEL_BIT;
            end
            irpsg_pkg::PH_GAP: begin
                cmd.emit    = status.out_free;
                cmd.sel     = irpsg_pkg::SEL_DELAY;
                cmd.last    = status.final_bit;
                cmd.advance = status.out_free;
            end
            irpsg_pkg::PH_REJECT: begin
                cmd.emit     = status.out_free;
                cmd.sel      = irpsg_pkg::SEL_NONE;
                cmd.last     = 1'b1;
                cmd.rejected = 1'b1;
            end
            default: begin
                cmd.emit = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: hw/rtl/irpsg_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// irpsg_dp
// Datapath: timing registers, command shift register, bit counter and the
// output register of the duration channel.
// ============================================================================
module irpsg_dp #(
    parameter int MAX_BITS = irpsg_pkg::MAX_BITS_DEFAULT
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire  [irpsg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [irpsg_pkg::DUR_W-1:0]           cfg_data,
    input  wire  [irpsg_pkg::WORD_W-1:0]          s_command_word,
    input  wire  [irpsg_pkg::COUNT_W-1:0]         s_bit_count,
    output logic                                  m_valid,
    input  wire                                   m_ready,
    output logic [irpsg_pkg::DUR_W-1:0]           m_duration,
    output logic                                  m_last,
    output logic                                  m_rejected,
    input  wire irpsg_pkg::dp_cmd_t               cmd,
    output irpsg_pkg::dp_status_t                 status
);

    logic [irpsg_pkg::DUR_W-1:0]   hdr_high_reg;
    logic [irpsg_pkg::DUR_W-1:0]   hdr_low_reg;
    logic [irpsg_pkg::DUR_W-1:0]   delay_reg;
    logic [irpsg_pkg::DUR_W-1:0]   zero_bit_reg;
    logic [irpsg_pkg::DUR_W-1:0]   one_bit_reg;
    logic                          delay_mode_reg;
    logic [irpsg_pkg::WORD_W-1:0]  shift_reg;
    logic [irpsg_pkg::COUNT_W-1:0] bits_left_reg;
    logic                          m_valid_reg;
    logic [irpsg_pkg::DUR_W-1:0]   m_duration_reg;
    logic                          m_last_reg;
    logic                          m_rejected_reg;
    logic [irpsg_pkg::DUR_W-1:0]   dur_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_high_reg   <= irpsg_pkg::HDR_HIGH_RESET;
            hdr_low_reg    <= irpsg_pkg::HDR_LOW_RESET;
            delay_reg      <= irpsg_pkg::DELAY_RESET;
            zero_bit_reg   <= irpsg_pkg::ZERO_BIT_RESET;
            one_bit_reg    <= irpsg_pkg::ONE_BIT_RESET;
            delay_mode_reg <= irpsg_pkg::DELAY_MODE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                irpsg_pkg::REG_HDR_HIGH:   hdr_high_reg   <= cfg_data;
                irpsg_pkg::REG_HDR_LOW:    hdr_low_reg    <= cfg_data;
                irpsg_pkg::REG_DELAY:      delay_reg      <= cfg_data;
                irpsg_pkg::REG_ZERO_BIT:   zero_bit_reg   <= cfg_data;
                irpsg_pkg::REG_ONE_BIT:    one_bit_reg    <= cfg_data;
                irpsg_pkg::REG_DELAY_MODE: delay_mode_reg <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg     <= '0;
            bits_left_reg <= '0;
        end else if (cmd.load) begin
            shift_reg     <= s_command_word;
            bits_left_reg <= s_bit_count;
        end else if (cmd.advance) begin
            shift_reg     <= {1'b0, shift_reg[irpsg_pkg::WORD_W-1:1]};
            bits_left_reg <= bits_left_reg - irpsg_pkg::COUNT_W'(1);
        end
    end

    always_comb begin
        case (cmd.sel)
            irpsg_pkg::SEL_HDR_HIGH: dur_next = hdr_high_reg;
            irpsg_pkg::SEL_HDR_LOW:  dur_next = hdr_low_reg;
            irpsg_pkg::SEL_DELAY:    dur_next = delay_reg;
            irpsg_pkg::SEL_BIT:      dur_next = shift_reg[0] ? one_bit_reg : zero_bit_reg;
            default:                 dur_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_duration_reg <= dur_next;
            m_last_reg     <= cmd.last;
            m_rejected_reg <= cmd.rejected;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_duration = m_duration_reg;
    assign m_last     = m_last_reg;
    assign m_rejected = m_rejected_reg;

    assign status.out_free    = !m_valid_reg || m_ready;
    assign status.hdr_high_nz = (hdr_high_reg != '0);
    assign status.hdr_low_nz  = (hdr_low_reg != '0);
    assign status.delay_mode  = delay_mode_reg;
    assign status.bad_cmd     = (s_bit_count == '0)
                             || (s_bit_count > irpsg_pkg::COUNT_W'(MAX_BITS))
                             || (one_bit_reg == '0)
                             || (zero_bit_reg == '0);
    assign status.final_bit   = (bits_left_reg == irpsg_pkg::COUNT_W'(1));

endmodule
`default_nettype wire

FILE: hw/rtl/ir_pulse_sequence_generator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ir_pulse_sequence_generator_top
// IR pulse sequence generator: command word to pulse and gap durations.
// ============================================================================
// One command is taken when s_ready is high (sequencer idle). It is answered
// by the header mark and space when nonzero, an optional delay, and for each
// bit (LSB first) the one- or zero-bit time followed by the delay time; the
// final beat carries m_last. A bad command (bit count zero or above MAX_BITS,
// or a zero bit time) gives one beat with m_rejected and m_last set.
// A command gives R result beats, at most 3 + 2 * bit_count (63 at 30
// bits). The sequencer produces one duration per cycle into a single output
// register, unless m_ready holds the output. Configuration writes are
// accepted every cycle and are to be made while no command is in progress.
module ir_pulse_sequence_generator_top #(
    parameter int MAX_BITS = irpsg_pkg::MAX_BITS_DEFAULT
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [irpsg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire  [irpsg_pkg::DUR_W-1:0]      cfg_data,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire  [irpsg_pkg::WORD_W-1:0]     s_command_word,
    input  wire  [irpsg_pkg::COUNT_W-1:0]    s_bit_count,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [irpsg_pkg::DUR_W-1:0]      m_duration,
    output logic                             m_last,
    output logic                             m_rejected
);

    irpsg_pkg::dp_cmd_t    cmd;
    irpsg_pkg::dp_status_t status;

    irpsg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    irpsg_dp #(
        .MAX_BITS (MAX_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_command_word (s_command_word),
        .s_bit_count    (s_bit_count),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_duration     (m_duration),
        .m_last         (m_last),
        .m_rejected     (m_rejected),
        .cmd            (cmd),
        .status         (status)
    );

endmodule
`default_nettype wire

FILE: hw/rtl/irpsg_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// irpsg_checker
// Port-level checks of the IR pulse sequence generator.
// ============================================================================
module irpsg_checker (
    input wire                              aclk,
    input wire                              aresetn,
    input wire                              s_valid,
    input wire                              s_ready,
    input wire                              m_valid,
    input wire                              m_ready,
    input wire [irpsg_pkg::DUR_W-1:0]       m_duration,
    input wire                              m_last,
    input wire                              m_rejected
);

    // a refused command ends in the same beat
    a_reject_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rejected |-> m_last)
        else $error("rejected beat without last");

    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rejected |-> m_duration == '0)
        else $error("rejected beat with nonzero duration");

    // no new command while one is being sent
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("command taken while sequencer busy");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_duration) && $stable(m_last))
        else $error("output beat changed while stalled");

endmodule

bind ir_pulse_sequence_generator_top irpsg_checker u_irpsg_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_duration (m_duration),
    .m_last     (m_last),
    .m_rejected (m_rejected)
);
`default_nettype wire

FILE: tb/sv/tb_ir_pulse_sequence_generator_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_ir_pulse_sequence_generator_top
// Self-checking bench for the IR pulse sequence generator. A directed table
// covers field extremes, every refusal case and all registers. Randomized
// phases follow, each with its own register settings. Every command that is
// accepted, bar refusal rows, goes to a pulse-train predictor. Each beat is
// compared with the oldest predicted beat. Both channels stall at random.
// ============================================================================
module tb_ir_pulse_sequence_generator_top;

    import irpsg_pkg::*;

    localparam int MAX_BITS = MAX_BITS_DEFAULT;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE0 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE1 = 3'd7;
    localparam int PHASES = 6;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int DRAIN_CYCLES = 4;
    localparam int TAIL_CYCLES = 80;

    typedef struct packed {
        logic [DUR_W-1:0] duration;
        logic             last;
        logic             rejected;
    } ir_beat_t;

    typedef enum logic [1:0] {
        ROW_CMD,
        ROW_REJECT,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [DUR_W-1:0]     data;
        logic [WORD_W-1:0]    word;
        logic [COUNT_W-1:0]   count;
    } stim_row_t;

    localparam int N_ROWS = 25;
    stim_row_t directed_rows [0:N_ROWS-1] = '{
        '{ROW_CMD,    REG_HDR_HIGH,   16'h0000, 32'hFFFF_FFFF, 6'd30},
        '{ROW_CMD,    REG_HDR_HIGH,   16'h0000, 32'h0000_0000, 6'd30},
        '{ROW_CMD,    REG_HDR_HIGH,   16'h0000, 32'hA5A5_A5A5, 6'd1},
        '{ROW_REJECT, REG_HDR_HIGH,   16'h0000, 32'hFFFF_FFFF, 6'd0},
        '{ROW_REJECT, REG_HDR_HIGH,   16'h0000, 32'h1234_5678, 6'd31},
        '{ROW_REJECT, REG_HDR_HIGH,   16'h0000, 32'hFFFF_FFFF, 6'd63},
        '{ROW_CMD,    REG_HDR_HIGH,   16'h0000, 32'h1234_5678, 6'd17},
        '{ROW_CFG,    REG_ZERO_BIT,   16'h0000, 32'h0000_0000, 6'd0},
        '{ROW_REJECT, REG_HDR_HIGH,   16'h0000, 32'h0000_0005, 6'd4},
        '{ROW_CFG,    REG_ZERO_BIT,   16'hFFFF, 32'h0000_0000, 6'd0},
        '{ROW_CFG,    REG_ONE_BIT,    16'h0000, 32'h0000_0000, 6'd0},
        '{ROW_REJECT, REG_HDR_HIGH,   16'h0000, 32'h0000_FFFF, 6'd16},
        '{ROW_CFG,    REG_ONE_BIT,    16'h0001, 32'h0000_0000, 6'd0},
        '{ROW_CFG,    REG_HDR_HIGH,   16'h0000, 32'h0000_0000, 6'd0},
        '{ROW_CFG,    REG_HDR_LOW,    16'h0000, 32'h0000_0000, 6'd0},
        '{ROW_CFG,    REG_DELAY_MODE, 16'h0000, 32'h0000_0000, 6'd0},
        '{ROW_CMD,    REG_HDR_HIGH,   16'h0000, 32'h3FFF_FFFE, 6'd30},
        '{ROW_CMD,    REG_HDR_HIGH,   16'h0000, 32'h0000_0001, 6'd1},
        '{ROW_CFG,    REG_SPARE0,     16'h1234, 32'h0000_0000, 6'd0},
        '{ROW_CFG,    REG_SPARE1,     16'hFFFF, 32'h0000_0000, 6'd0},
        '{ROW_CFG,    REG_HDR_HIGH,   16'hFFFF, 32'h0000_0000, 6'd0},
        '{ROW_CFG,    REG_HDR_LOW,    16'hFFFF, 32'h0000_0000, 6'd0},
        '{ROW_CFG,    REG_DELAY,      16'h0000, 32'h0000_0000, 6'd0},
        '{ROW_CFG,    REG_DELAY_MODE, 16'hFFFF, 32'h0000_0000, 6'd0},
        '{ROW_CMD,    REG_HDR_HIGH,   16'h0000, 32'h5555_5555, 6'd30}
    };

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DUR_W-1:0]     cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [WORD_W-1:0]    s_command_word;
    logic [COUNT_W-1:0]   s_bit_count;
    logic                 m_valid;
    logic                 m_ready;
    logic [DUR_W-1:0]     m_duration;
    logic                 m_last;
    logic                 m_rejected;

    logic [DUR_W-1:0] hdr_high_time;
    logic [DUR_W-1:0] hdr_low_time;
    logic [DUR_W-1:0] gap_time;
    logic [DUR_W-1:0] zero_time;
    logic [DUR_W-1:0] one_time;
    logic             gap_after_header;

    ir_beat_t expected_beats[$];
    int       n_errors = 0;
    int       n_commands = 0;
    int       n_refused = 0;
    int       n_beats = 0;
    int       n_cfg_writes = 0;
    bit       tx_burst = 0;
    bit       rx_burst = 0;

    ir_pulse_sequence_generator_top #(
        .MAX_BITS(MAX_BITS)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command_word(s_command_word),
        .s_bit_count   (s_bit_count),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_duration    (m_duration),
        .m_last        (m_last),
        .m_rejected    (m_rejected)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("FAIL ir_pulse_sequence_generator_top");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        n_errors++;
        $display("ERROR %s: expected %0d got %0d at %0t", what, want, got, $realtime);
    endtask

    function automatic void reset_registers();
        hdr_high_time    = HDR_HIGH_RESET;
        hdr_low_time     = HDR_LOW_RESET;
        gap_time         = DELAY_RESET;
        zero_time        = ZERO_BIT_RESET;
        one_time         = ONE_BIT_RESET;
        gap_after_header = DELAY_MODE_RESET;
    endfunction

    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [DUR_W-1:0] data);
        case (idx)
            REG_HDR_HIGH:   hdr_high_time = data;
            REG_HDR_LOW:    hdr_low_time = data;
            REG_DELAY:      gap_time = data;
            REG_ZERO_BIT:   zero_time = data;
            REG_ONE_BIT:    one_time = data;
            REG_DELAY_MODE: gap_after_header = data[0];
            default: ;
        endcase
    endfunction

    function automatic void push_beat(logic [DUR_W-1:0] dur, int k, int total);
        ir_beat_t b;
        b.duration = dur;
        b.last     = (k == total - 1);
        b.rejected = 1'b0;
        expected_beats.push_back(b);
    endfunction

    function automatic void push_refusal();
        ir_beat_t b;
        b.duration = '0;
        b.last     = 1'b1;
        b.rejected = 1'b1;
        expected_beats.push_back(b);
        n_refused++;
    endfunction

    function automatic void predict_pulse_train(logic [WORD_W-1:0] word,
                                                logic [COUNT_W-1:0] count);
        int total;
        int k;
        if (count == 0 || count > MAX_BITS || one_time == 0 || zero_time == 0) begin
            push_refusal();
        end else begin
            total = int'(hdr_high_time != 0) + int'(hdr_low_time != 0)
                  + int'(gap_after_header) + 2 * int'(count);
            k = 0;
            if (hdr_high_time != 0) begin
                push_beat(hdr_high_time, k, total);
                k++;
            end
            if (hdr_low_time != 0) begin
                push_beat(hdr_low_time, k, total);
                k++;
            end
            if (gap_after_header) begin
                push_beat(gap_time, k, total);
                k++;
            end
            for (int i = 0; i < int'(count); i++) begin
                push_beat(word[i] ? one_time : zero_time, k, total);
                k++;
                push_beat(gap_time, k, total);
                k++;
            end
        end
    endfunction

    task automatic send_command(input logic [WORD_W-1:0] word, input logic [COUNT_W-1:0] count,
                                input bit typed_refusal);
        int gap;
        s_valid        = 1'b1;
        s_command_word = word;
        s_bit_count    = count;
        do @(posedge aclk); while (!s_ready);
        if (typed_refusal) begin
            push_refusal();
        end else begin
            predict_pulse_train(word, count);
        end
        n_commands++;
        @(negedge aclk);
        s_valid = 1'b0;
        gap = tx_burst ? 0 : $urandom_range(0, 12);
        repeat (gap) @(negedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [DUR_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge aclk); while (!cfg_ready);
        apply_register(idx, data);
        n_cfg_writes++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_beats.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [DUR_W-1:0] pick_setting(bit allow_zero);
        logic [DUR_W-1:0] v;
        case ($urandom_range(0, 7))
            0:       v = allow_zero ? 16'h0000 : 16'h0001;
            1:       v = 16'hFFFF;
            2:       v = 16'h0001;
            default: v = DUR_W'($urandom);
        endcase
        if (!allow_zero && v == 0) v = 16'h0001;
        return v;
    endfunction

    task automatic program_phase(input int phase_no);
        wait_drained();
        if (phase_no == 0) begin
            write_register(REG_HDR_HIGH, 16'hFFFF);
            write_register(REG_HDR_LOW, 16'hFFFF);
            write_register(REG_DELAY, 16'hFFFF);
            write_register(REG_ZERO_BIT, 16'hFFFF);
            write_register(REG_ONE_BIT, 16'hFFFF);
            write_register(REG_DELAY_MODE, 16'h0001);
        end else if (phase_no == 1) begin
            write_register(REG_HDR_HIGH, 16'h0000);
            write_register(REG_HDR_LOW, 16'h0000);
            write_register(REG_DELAY, 16'h0000);
            write_register(REG_ZERO_BIT, 16'h0001);
            write_register(REG_ONE_BIT, 16'h0001);
            write_register(REG_DELAY_MODE, 16'h0000);
        end else begin
            write_register(REG_HDR_HIGH, pick_setting(1'b1));
            write_register(REG_HDR_LOW, pick_setting(1'b1));
            write_register(REG_DELAY, pick_setting(1'b1));
            write_register(REG_ZERO_BIT, pick_setting($urandom_range(0, 9) == 0));
            write_register(REG_ONE_BIT, pick_setting($urandom_range(0, 9) == 0));
            write_register(REG_DELAY_MODE, DUR_W'($urandom));
            if ($urandom_range(0, 1) == 0) begin
                write_register($urandom_range(0, 1) ? REG_SPARE0 : REG_SPARE1,
                               DUR_W'($urandom));
            end
        end
    endtask

    task automatic send_random_command();
        logic [COUNT_W-1:0] count;
        case ($urandom_range(0, 19))
            0:       count = '0;
            1:       count = COUNT_W'($urandom_range(MAX_BITS + 1, 63));
            2, 3, 4: count = COUNT_W'($urandom_range(20, MAX_BITS));
            default: count = COUNT_W'($urandom_range(1, 19));
        endcase
        send_command($urandom, count, 1'b0);
    endtask

    initial begin
        int       stall;
        ir_beat_t want;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, 12);
            repeat (stall) @(negedge aclk);
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            n_beats++;
            if (expected_beats.size() == 0) begin
                report_mismatch("beat with nothing pending", 0, m_duration);
            end else begin
                want = expected_beats.pop_front();
                if (m_duration !== want.duration)
                    report_mismatch("duration", want.duration, m_duration);
                if (m_last !== want.last)
                    report_mismatch("last", want.last, m_last);
                if (m_rejected !== want.rejected)
                    report_mismatch("rejected", want.rejected, m_rejected);
            end
            @(negedge aclk);
            m_ready = 1'b0;
        end
    end

    initial begin
        aclk           = 1'b0;
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_command_word = '0;
        s_bit_count    = '0;
        reset_registers();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        for (int r = 0; r < N_ROWS; r++) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                wait_drained();
                write_register(directed_rows[r].idx, directed_rows[r].data);
            end else begin
                send_command(directed_rows[r].word, directed_rows[r].count,
                             directed_rows[r].kind == ROW_REJECT);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            program_phase(p);
            tx_burst = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                // hold the sender until the pipe is empty
                if ((p == 2 && i == 20) || $urandom_range(0, 49) == 0) wait_drained();
                send_random_command();
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (expected_beats.size() != 0)
            report_mismatch("beats never delivered", 0, expected_beats.size());

        $display("Covered %0d commands (%0d refused), %0d output beats checked,",
                 n_commands, n_refused, n_beats);
        $display("%0d register writes across %0d random phases plus the directed table.",
                 n_cfg_writes, PHASES);
        if (n_errors == 0) begin
            $display("PASS ir_pulse_sequence_generator_top");
        end else begin
            $display("FAIL ir_pulse_sequence_generator_top");
        end
        $finish;
    end

endmodule
